// ===== rtl/rvid_pkg.sv =====
// rv32i decoder package: opcodes, format classes, operation codes
`timescale 1ns / 1ps

package rvid_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned FmtWidth  = 3;
   localparam int unsigned OpWidth   = 6;
   localparam int unsigned RegWidth  = 5;

   typedef logic [6:0] opcode_type;
   typedef logic [FmtWidth-1:0] format_type;
   typedef logic [OpWidth-1:0] operation_type;

   // major opcodes
   localparam opcode_type OPC_OP     = 7'b0110011;
   localparam opcode_type OPC_OP_IMM = 7'b0010011;
   localparam opcode_type OPC_JALR   = 7'b1100111;
   localparam opcode_type OPC_LOAD   = 7'b0000011;
   localparam opcode_type OPC_STORE  = 7'b0100011;
   localparam opcode_type OPC_BRANCH = 7'b1100011;
   localparam opcode_type OPC_LUI    = 7'b0110111;
   localparam opcode_type OPC_AUIPC  = 7'b0010111;
   localparam opcode_type OPC_JAL    = 7'b1101111;
   localparam opcode_type OPC_SYSTEM = 7'b1110011;

   localparam logic [6:0] FUNCT7_ALT  = 7'b0100000;
   localparam logic [6:0] FUNCT7_ZERO = 7'b0000000;
   localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;

   // format classes
   localparam format_type FMT_R       = 3'd0;
   localparam format_type FMT_I       = 3'd1;
   localparam format_type FMT_S       = 3'd2;
   localparam format_type FMT_B       = 3'd3;
   localparam format_type FMT_U       = 3'd4;
   localparam format_type FMT_J       = 3'd5;
   localparam format_type FMT_UNKNOWN = 3'd6;

   // dense operation codes
   localparam operation_type OP_UNKNOWN = 6'd0;
   localparam operation_type OP_ADD     = 6'd1;
   localparam operation_type OP_SUB     = 6'd2;
   localparam operation_type OP_SLT     = 6'd3;
   localparam operation_type OP_SLTU    = 6'd4;
   localparam operation_type OP_AND     = 6'd5;
   localparam operation_type OP_OR      = 6'd6;
   localparam operation_type OP_XOR     = 6'd7;
   localparam operation_type OP_SLL     = 6'd8;
   localparam operation_type OP_SRL     = 6'd9;
   localparam operation_type OP_SRA     = 6'd10;
   localparam operation_type OP_ADDI    = 6'd11;
   localparam operation_type OP_SLTI    = 6'd12;
   localparam operation_type OP_SLTIU   = 6'd13;
   localparam operation_type OP_ANDI    = 6'd14;
   localparam operation_type OP_ORI     = 6'd15;
   localparam operation_type OP_XORI    = 6'd16;
   localparam operation_type OP_SLLI    = 6'd17;
   localparam operation_type OP_SRLI    = 6'd18;
   localparam operation_type OP_SRAI    = 6'd19;
   localparam operation_type OP_JALR    = 6'd20;
   localparam operation_type OP_LW      = 6'd21;
   localparam operation_type OP_LH      = 6'd22;
   localparam operation_type OP_LHU     = 6'd23;
   localparam operation_type OP_LB      = 6'd24;
   localparam operation_type OP_LBU     = 6'd25;
   localparam operation_type OP_SW      = 6'd26;
   localparam operation_type OP_SH      = 6'd27;
   localparam operation_type OP_SB      = 6'd28;
   localparam operation_type OP_BEQ     = 6'd29;
   localparam operation_type OP_BNE     = 6'd30;
   localparam operation_type OP_BLT     = 6'd31;
   localparam operation_type OP_BGE     = 6'd32;
   localparam operation_type OP_BLTU    = 6'd33;
   localparam operation_type OP_BGEU    = 6'd34;
   localparam operation_type OP_LUI     = 6'd35;
   localparam operation_type OP_AUIPC   = 6'd36;
   localparam operation_type OP_JAL     = 6'd37;
   localparam operation_type OP_ECALL   = 6'd38;
   localparam operation_type OP_EBREAK  = 6'd39;

endpackage

// ===== rtl/rv32i_instruction_decoder_unit.sv =====
// rv32i instruction decoder: input register, decode logic, result register
//
// usage:
//   an instruction word beat is taken on req_instr_word at a rising edge where
//   start is high and busy is low; busy stays low, so a word may be offered
//   in every cycle
//   the decoded result appears on the rsp_ ports with rsp_valid high for
//   exactly one cycle, after the input register and then the result register
//   a word passes the input register, then the result register; throughput:
//   one word per cycle, set by the single decode stage between the registers
//   the receiver cannot stall: every result beat is taken when shown
//   reset (synchronous, active high) clears both valid flags; words in
//   flight are dropped and no result beat follows reset
//   unknown opcodes give format unknown and operation unknown with the
//   register and immediate fields zero; the system opcode gives ecall or
//   ebreak under format unknown
//
`timescale 1ns / 1ps

module rv32i_instruction_decoder_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [rvid_pkg::WordWidth-1:0]        req_instr_word,
   output logic                                  rsp_valid,
   output logic [rvid_pkg::FmtWidth-1:0]         rsp_format_class,
   output logic [rvid_pkg::OpWidth-1:0]          rsp_operation,
   output logic [rvid_pkg::RegWidth-1:0]         rsp_dest_reg,
   output logic [rvid_pkg::RegWidth-1:0]         rsp_src1_reg,
   output logic [rvid_pkg::RegWidth-1:0]         rsp_src2_reg,
   output logic signed [rvid_pkg::WordWidth-1:0] rsp_immediate
);

   logic                               word_valid_ff;
   logic [rvid_pkg::WordWidth-1:0]     word_ff;

   logic                               rsp_valid_ff;
   rvid_pkg::format_type               fmt_ff, fmt_in;
   rvid_pkg::operation_type            op_ff, op_in;
   logic [rvid_pkg::RegWidth-1:0]      rd_ff, rd_in;
   logic [rvid_pkg::RegWidth-1:0]      rs1_ff, rs1_in;
   logic [rvid_pkg::RegWidth-1:0]      rs2_ff, rs2_in;
   logic [rvid_pkg::WordWidth-1:0]     imm_ff, imm_in;

   logic [6:0]                         opc;
   logic [2:0]                         f3;
   logic [6:0]                         f7;
   logic [rvid_pkg::RegWidth-1:0]      rd, rs1, rs2;
   logic [rvid_pkg::WordWidth-1:0]     imm_i, imm_s, imm_b, imm_u, imm_j;

   assign busy = 1'b0;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
      end else begin
         word_valid_ff <= start & ~busy;
      end
      if (start & ~busy) begin
         word_ff <= req_instr_word;
      end
   end

   // field extraction
   assign opc = word_ff[6:0];
   assign rd  = word_ff[11:7];
   assign f3  = word_ff[14:12];
   assign rs1 = word_ff[19:15];
   assign rs2 = word_ff[24:20];
   assign f7  = word_ff[31:25];

   assign imm_i = {{20{word_ff[31]}}, word_ff[31:20]};
   assign imm_s = {{20{word_ff[31]}}, word_ff[31:25], word_ff[11:7]};
   assign imm_b = {{19{word_ff[31]}}, word_ff[31], word_ff[7], word_ff[30:25],
                   word_ff[11:8], 1'b0};
   assign imm_u = word_ff & rvid_pkg::UPPER_MASK;
   assign imm_j = {{11{word_ff[31]}}, word_ff[31], word_ff[19:12], word_ff[20],
                   word_ff[30:21], 1'b0};

   // decode
   always_comb begin
      fmt_in = rvid_pkg::FMT_UNKNOWN;
      op_in  = rvid_pkg::OP_UNKNOWN;
      rd_in  = '0;
      rs1_in = '0;
      rs2_in = '0;
      imm_in = '0;
      unique case (opc)
         rvid_pkg::OPC_OP: begin
            fmt_in = rvid_pkg::FMT_R;
            rd_in  = rd;
            rs1_in = rs1;
            rs2_in = rs2;
            unique case (f3)
               3'd0: begin
                  if (f7 == rvid_pkg::FUNCT7_ALT) op_in = rvid_pkg::OP_SUB;
                  else if (f7 == rvid_pkg::FUNCT7_ZERO) op_in = rvid_pkg::OP_ADD;
                  else op_in = rvid_pkg::OP_UNKNOWN;
               end
               3'd1: op_in = rvid_pkg::OP_SLL;
               3'd2: op_in = rvid_pkg::OP_SLT;
               3'd3: op_in = rvid_pkg::OP_SLTU;
               3'd4: op_in = rvid_pkg::OP_XOR;
               3'd5: begin
                  if (f7 == rvid_pkg::FUNCT7_ALT) op_in = rvid_pkg::OP_SRA;
                  else if (f7 == rvid_pkg::FUNCT7_ZERO) op_in = rvid_pkg::OP_SRL;
                  else op_in = rvid_pkg::OP_UNKNOWN;
               end
               3'd6: op_in = rvid_pkg::OP_OR;
               3'd7: op_in = rvid_pkg::OP_AND;
               default: op_in = rvid_pkg::OP_UNKNOWN;
            endcase
         end
         rvid_pkg::OPC_OP_IMM: begin
            fmt_in = rvid_pkg::FMT_I;
            rd_in  = rd;
            rs1_in = rs1;
            imm_in = imm_i;
            unique case (f3)
               3'd0: op_in = rvid_pkg::OP_ADDI;
               3'd1: op_in = rvid_pkg::OP_SLLI;
               3'd2: op_in = rvid_pkg::OP_SLTI;
               3'd3: op_in = rvid_pkg::OP_SLTIU;
               3'd4: op_in = rvid_pkg::OP_XORI;
               3'd5: op_in = (f7 == rvid_pkg::FUNCT7_ZERO) ? rvid_pkg::OP_SRLI
                                                             : rvid_pkg::OP_SRAI;
               3'd6: op_in = rvid_pkg::OP_ORI;
               3'd7: op_in = rvid_pkg::OP_ANDI;
               default: op_in = rvid_pkg::OP_UNKNOWN;
            endcase
         end
         rvid_pkg::OPC_JALR: begin
            fmt_in = rvid_pkg::FMT_I;
            rd_in  = rd;
            rs1_in = rs1;
            imm_in = imm_i;
            op_in  = rvid_pkg::OP_JALR;
         end
         rvid_pkg::OPC_LOAD: begin
            fmt_in = rvid_pkg::FMT_I;
            rd_in  = rd;
            rs1_in = rs1;
            imm_in = imm_i;
            unique case (f3)
               3'd0:    op_in = rvid_pkg::OP_LB;
               3'd1:    op_in = rvid_pkg::OP_LH;
               3'd2:    op_in = rvid_pkg::OP_LW;
               3'd4:    op_in = rvid_pkg::OP_LBU;
               3'd5:    op_in = rvid_pkg::OP_LHU;
               default: op_in = rvid_pkg::OP_UNKNOWN;
            endcase
         end
         rvid_pkg::OPC_STORE: begin
            fmt_in = rvid_pkg::FMT_S;
            rs1_in = rs1;
            rs2_in = rs2;
            imm_in = imm_s;
            unique case (f3)
               3'd0:    op_in = rvid_pkg::OP_SB;
               3'd1:    op_in = rvid_pkg::OP_SH;
               3'd2:    op_in = rvid_pkg::OP_SW;
               default: op_in = rvid_pkg::OP_UNKNOWN;
            endcase
         end
         rvid_pkg::OPC_BRANCH: begin
            fmt_in = rvid_pkg::FMT_B;
            rs1_in = rs1;
            rs2_in = rs2;
            imm_in = imm_b;
            unique case (f3)
               3'd0:    op_in = rvid_pkg::OP_BEQ;
               3'd1:    op_in = rvid_pkg::OP_BNE;
               3'd4:    op_in = rvid_pkg::OP_BLT;
               3'd5:    op_in = rvid_pkg::OP_BGE;
               3'd6:    op_in = rvid_pkg::OP_BLTU;
               3'd7:    op_in = rvid_pkg::OP_BGEU;
               default: op_in = rvid_pkg::OP_UNKNOWN;
            endcase
         end
         rvid_pkg::OPC_LUI: begin
            fmt_in = rvid_pkg::FMT_U;
            rd_in  = rd;
            imm_in = imm_u;
            op_in  = rvid_pkg::OP_LUI;
         end
         rvid_pkg::OPC_AUIPC: begin
            fmt_in = rvid_pkg::FMT_U;
            rd_in  = rd;
            imm_in = imm_u;
            op_in  = rvid_pkg::OP_AUIPC;
         end
         rvid_pkg::OPC_JAL: begin
            fmt_in = rvid_pkg::FMT_J;
            rd_in  = rd;
            imm_in = imm_j;
            op_in  = rvid_pkg::OP_JAL;
         end
         rvid_pkg::OPC_SYSTEM: begin
            op_in = (word_ff[31:20] == 12'd0) ? rvid_pkg::OP_ECALL
                                              : rvid_pkg::OP_EBREAK;
         end
         default: begin
            fmt_in = rvid_pkg::FMT_UNKNOWN;
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= word_valid_ff;
      end
      if (word_valid_ff) begin
         fmt_ff <= fmt_in;
         op_ff  <= op_in;
         rd_ff  <= rd_in;
         rs1_ff <= rs1_in;
         rs2_ff <= rs2_in;
         imm_ff <= imm_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_format_class = fmt_ff;
   assign rsp_operation    = op_ff;
   assign rsp_dest_reg     = rd_ff;
   assign rsp_src1_reg     = rs1_ff;
   assign rsp_src2_reg     = rs2_ff;
   assign rsp_immediate    = signed'(imm_ff);

endmodule

// ===== rtl/rvid_checker.sv =====
// port-level checker for the rv32i decoder and its bind
`timescale 1ns / 1ps

module rvid_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic [rvid_pkg::WordWidth-1:0]        req_instr_word,
   input logic                                  rsp_valid,
   input logic [rvid_pkg::FmtWidth-1:0]         rsp_format_class,
   input logic [rvid_pkg::OpWidth-1:0]          rsp_operation,
   input logic [rvid_pkg::RegWidth-1:0]         rsp_dest_reg,
   input logic [rvid_pkg::RegWidth-1:0]         rsp_src1_reg,
   input logic [rvid_pkg::RegWidth-1:0]         rsp_src2_reg,
   input logic signed [rvid_pkg::WordWidth-1:0] rsp_immediate
);

   // every accepted beat gives a result beat after the input and result registers
   a_accept_to_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted word produced no result beat");

   // no result beat without an earlier accepted word
   a_result_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result beat without accepted word");

   // register type results carry rd of the accepted word that produced them
   a_rtype_rd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_format_class == rvid_pkg::FMT_R)
         |-> rsp_dest_reg == $past(req_instr_word[11:7], 2))
      else $error("rd does not match accepted word");

   // unknown format carries only the operation
   a_unknown_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_format_class == rvid_pkg::FMT_UNKNOWN)
         |-> (rsp_dest_reg == '0 && rsp_src1_reg == '0 && rsp_src2_reg == '0
              && rsp_immediate == '0
              && (rsp_operation == rvid_pkg::OP_UNKNOWN
                  || rsp_operation == rvid_pkg::OP_ECALL
                  || rsp_operation == rvid_pkg::OP_EBREAK)))
      else $error("unknown format with nonzero fields");

endmodule

bind rv32i_instruction_decoder_unit rvid_checker u_rvid_checker (.*);

// ===== tb/testbench.sv =====
// testbench for the rv32i instruction decoder: reference decode, directed and random words
`timescale 1ns / 1ps

module testbench;

   localparam int CycleLimit  = 200000;
   localparam int RandomWords = 1800;

   typedef struct packed {
      rvid_pkg::format_type    fmt;
      rvid_pkg::operation_type op;
      logic [4:0]              rd;
      logic [4:0]              rs1;
      logic [4:0]              rs2;
      logic [31:0]             imm;
   } decoded_type;

   class decode_checker;
      decoded_type pending_decodes[$];
      int          mismatches;
      int          orphans;
      int          checked;
      int          per_format[8];

      function decoded_type decode_word(logic [31:0] w);
         decoded_type          d;
         rvid_pkg::opcode_type opc;
         logic [2:0]           f3;
         logic [6:0]           f7;
         opc = w[6:0];
         f3 = w[14:12];
         f7 = w[31:25];
         d = '{rvid_pkg::FMT_UNKNOWN, rvid_pkg::OP_UNKNOWN, 5'd0, 5'd0, 5'd0, 32'd0};
         case (opc)
            rvid_pkg::OPC_OP: begin
               d.fmt = rvid_pkg::FMT_R;
               d.rd = w[11:7];
               d.rs1 = w[19:15];
               d.rs2 = w[24:20];
               case (f3)
                  3'd0: d.op = (f7 == rvid_pkg::FUNCT7_ZERO) ? rvid_pkg::OP_ADD :
                               (f7 == rvid_pkg::FUNCT7_ALT) ? rvid_pkg::OP_SUB :
                               rvid_pkg::OP_UNKNOWN;
                  3'd1: d.op = rvid_pkg::OP_SLL;
                  3'd2: d.op = rvid_pkg::OP_SLT;
                  3'd3: d.op = rvid_pkg::OP_SLTU;
                  3'd4: d.op = rvid_pkg::OP_XOR;
                  3'd5: d.op = (f7 == rvid_pkg::FUNCT7_ZERO) ? rvid_pkg::OP_SRL :
                               (f7 == rvid_pkg::FUNCT7_ALT) ? rvid_pkg::OP_SRA :
                               rvid_pkg::OP_UNKNOWN;
                  3'd6: d.op = rvid_pkg::OP_OR;
                  default: d.op = rvid_pkg::OP_AND;
               endcase
            end
            rvid_pkg::OPC_OP_IMM, rvid_pkg::OPC_JALR, rvid_pkg::OPC_LOAD: begin
               d.fmt = rvid_pkg::FMT_I;
               d.rd = w[11:7];
               d.rs1 = w[19:15];
               d.imm = {{20{w[31]}}, w[31:20]};
               if (opc == rvid_pkg::OPC_JALR) begin
                  d.op = rvid_pkg::OP_JALR;
               end else if (opc == rvid_pkg::OPC_OP_IMM) begin
                  case (f3)
                     3'd0: d.op = rvid_pkg::OP_ADDI;
                     3'd1: d.op = rvid_pkg::OP_SLLI;
                     3'd2: d.op = rvid_pkg::OP_SLTI;
                     3'd3: d.op = rvid_pkg::OP_SLTIU;
                     3'd4: d.op = rvid_pkg::OP_XORI;
                     3'd5: d.op = (f7 == rvid_pkg::FUNCT7_ZERO) ? rvid_pkg::OP_SRLI
                                                                 : rvid_pkg::OP_SRAI;
                     3'd6: d.op = rvid_pkg::OP_ORI;
                     default: d.op = rvid_pkg::OP_ANDI;
                  endcase
               end else begin
                  case (f3)
                     3'd0: d.op = rvid_pkg::OP_LB;
                     3'd1: d.op = rvid_pkg::OP_LH;
                     3'd2: d.op = rvid_pkg::OP_LW;
                     3'd4: d.op = rvid_pkg::OP_LBU;
                     3'd5: d.op = rvid_pkg::OP_LHU;
                     default: d.op = rvid_pkg::OP_UNKNOWN;
                  endcase
               end
            end
            rvid_pkg::OPC_STORE: begin
               d.fmt = rvid_pkg::FMT_S;
               d.rs1 = w[19:15];
               d.rs2 = w[24:20];
               d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
               case (f3)
                  3'd0: d.op = rvid_pkg::OP_SB;
                  3'd1: d.op = rvid_pkg::OP_SH;
                  3'd2: d.op = rvid_pkg::OP_SW;
                  default: d.op = rvid_pkg::OP_UNKNOWN;
               endcase
            end
            rvid_pkg::OPC_BRANCH: begin
               d.fmt = rvid_pkg::FMT_B;
               d.rs1 = w[19:15];
               d.rs2 = w[24:20];
               d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
               case (f3)
                  3'd0: d.op = rvid_pkg::OP_BEQ;
                  3'd1: d.op = rvid_pkg::OP_BNE;
                  3'd4: d.op = rvid_pkg::OP_BLT;
                  3'd5: d.op = rvid_pkg::OP_BGE;
                  3'd6: d.op = rvid_pkg::OP_BLTU;
                  3'd7: d.op = rvid_pkg::OP_BGEU;
                  default: d.op = rvid_pkg::OP_UNKNOWN;
               endcase
            end
            rvid_pkg::OPC_LUI, rvid_pkg::OPC_AUIPC: begin
               d.fmt = rvid_pkg::FMT_U;
               d.rd = w[11:7];
               d.op = (opc == rvid_pkg::OPC_LUI) ? rvid_pkg::OP_LUI : rvid_pkg::OP_AUIPC;
               d.imm = w & rvid_pkg::UPPER_MASK;
            end
            rvid_pkg::OPC_JAL: begin
               d.fmt = rvid_pkg::FMT_J;
               d.rd = w[11:7];
               d.op = rvid_pkg::OP_JAL;
               d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
            rvid_pkg::OPC_SYSTEM: begin
               d.op = (w[31:20] == 12'd0) ? rvid_pkg::OP_ECALL : rvid_pkg::OP_EBREAK;
            end
            default: begin
            end
         endcase
         return d;
      endfunction

      function void note_word(logic [31:0] w);
         decoded_type d;
         d = decode_word(w);
         pending_decodes.push_back(d);
         per_format[d.fmt]++;
      endfunction

      function void check_decode(decoded_type got);
         decoded_type exp;
         if (pending_decodes.size() == 0) begin
            orphans++;
            $display("%0t: result beat with nothing pending: fmt %0d op %0d", $time,
                     got.fmt, got.op);
            return;
         end
         exp = pending_decodes.pop_front();
         checked++;
         if (got !== exp) begin
            mismatches++;
            if (got.fmt !== exp.fmt)
               $display("%0t: format expected %0d actual %0d", $time, exp.fmt, got.fmt);
            if (got.op !== exp.op)
               $display("%0t: operation expected %0d actual %0d", $time, exp.op, got.op);
            if (got.rd !== exp.rd)
               $display("%0t: dest_reg expected %0d actual %0d", $time, exp.rd, got.rd);
            if (got.rs1 !== exp.rs1)
               $display("%0t: src1_reg expected %0d actual %0d", $time, exp.rs1, got.rs1);
            if (got.rs2 !== exp.rs2)
               $display("%0t: src2_reg expected %0d actual %0d", $time, exp.rs2, got.rs2);
            if (got.imm !== exp.imm)
               $display("%0t: immediate expected %h actual %h", $time, exp.imm, got.imm);
         end
      endfunction
   endclass

   logic                                  clock;
   logic                                  reset;
   logic                                  start;
   logic                                  busy;
   logic [rvid_pkg::WordWidth-1:0]        req_instr_word;
   logic                                  rsp_valid;
   logic [rvid_pkg::FmtWidth-1:0]         rsp_format_class;
   logic [rvid_pkg::OpWidth-1:0]          rsp_operation;
   logic [rvid_pkg::RegWidth-1:0]         rsp_dest_reg;
   logic [rvid_pkg::RegWidth-1:0]         rsp_src1_reg;
   logic [rvid_pkg::RegWidth-1:0]         rsp_src2_reg;
   logic signed [rvid_pkg::WordWidth-1:0] rsp_immediate;

   decode_checker        sb;
   int                   cycle_count;
   int                   words_sent;
   rvid_pkg::opcode_type known_opcodes[10] = '{
      rvid_pkg::OPC_OP, rvid_pkg::OPC_OP_IMM, rvid_pkg::OPC_JALR, rvid_pkg::OPC_LOAD,
      rvid_pkg::OPC_STORE, rvid_pkg::OPC_BRANCH, rvid_pkg::OPC_LUI, rvid_pkg::OPC_AUIPC,
      rvid_pkg::OPC_JAL, rvid_pkg::OPC_SYSTEM};

   rv32i_instruction_decoder_unit uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_instr_word   (req_instr_word),
      .rsp_valid        (rsp_valid),
      .rsp_format_class (rsp_format_class),
      .rsp_operation    (rsp_operation),
      .rsp_dest_reg     (rsp_dest_reg),
      .rsp_src1_reg     (rsp_src1_reg),
      .rsp_src2_reg     (rsp_src2_reg),
      .rsp_immediate    (rsp_immediate)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_word(req_instr_word);
         if (rsp_valid)
            sb.check_decode('{rsp_format_class, rsp_operation, rsp_dest_reg, rsp_src1_reg,
                              rsp_src2_reg, rsp_immediate});
      end
   end

   function automatic logic [31:0] make_word(rvid_pkg::opcode_type opc, logic [2:0] f3,
                                             logic [6:0] f7);
      logic [31:0] w;
      w = $urandom();
      w[6:0] = opc;
      w[14:12] = f3;
      w[31:25] = f7;
      return w;
   endfunction

   function automatic logic [31:0] random_word();
      logic [31:0]          w;
      rvid_pkg::opcode_type opc;
      int                   pick;
      w = $urandom();
      if ($urandom_range(0, 9) == 0)
         return w;
      opc = known_opcodes[$urandom_range(0, 9)];
      w[6:0] = opc;
      if (opc == rvid_pkg::OPC_OP || opc == rvid_pkg::OPC_OP_IMM) begin
         pick = $urandom_range(0, 3);
         if (pick < 2)
            w[31:25] = rvid_pkg::FUNCT7_ZERO;
         else if (pick == 2)
            w[31:25] = rvid_pkg::FUNCT7_ALT;
      end else if (opc == rvid_pkg::OPC_SYSTEM && $urandom_range(0, 1) == 0) begin
         w[31:20] = 12'd0;
      end
      return w;
   endfunction

   task automatic send_word(logic [31:0] w);
      start <= 1'b1;
      req_instr_word <= w;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   task automatic maybe_idle(bit allowed);
      while (allowed && $urandom_range(0, 99) < 22) begin
         start <= 1'b0;
         req_instr_word <= $urandom();
         @(posedge clock);
      end
   endtask

   initial begin
      sb = new();
      cycle_count = 0;
      words_sent = 0;
      reset = 1'b1;
      start = 1'b0;
      req_instr_word = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every funct3 under each major opcode that uses one
      for (int f = 0; f < 8; f++) begin
         send_word(make_word(rvid_pkg::OPC_OP, f[2:0], rvid_pkg::FUNCT7_ZERO));
         send_word(make_word(rvid_pkg::OPC_OP_IMM, f[2:0], rvid_pkg::FUNCT7_ZERO));
         maybe_idle(1'b1);
         send_word(make_word(rvid_pkg::OPC_LOAD, f[2:0], 7'($urandom())));
         send_word(make_word(rvid_pkg::OPC_STORE, f[2:0], 7'($urandom())));
         send_word(make_word(rvid_pkg::OPC_BRANCH, f[2:0], 7'($urandom())));
      end
      // alternate funct7, bad funct7, ignored funct7
      send_word(make_word(rvid_pkg::OPC_OP, 3'd0, rvid_pkg::FUNCT7_ALT));
      send_word(make_word(rvid_pkg::OPC_OP, 3'd5, rvid_pkg::FUNCT7_ALT));
      send_word(make_word(rvid_pkg::OPC_OP, 3'd0, 7'b0000001));
      send_word(make_word(rvid_pkg::OPC_OP, 3'd5, 7'b1111111));
      send_word(make_word(rvid_pkg::OPC_OP, 3'd7, 7'b1010101));
      send_word(make_word(rvid_pkg::OPC_OP_IMM, 3'd5, rvid_pkg::FUNCT7_ALT));
      send_word(make_word(rvid_pkg::OPC_OP_IMM, 3'd1, 7'b1111111));
      send_word(make_word(rvid_pkg::OPC_JALR, 3'd3, 7'b1000000));
      send_word(make_word(rvid_pkg::OPC_LUI, 3'd0, 7'b1111111));
      send_word(make_word(rvid_pkg::OPC_AUIPC, 3'd0, 7'b0000000));
      send_word(make_word(rvid_pkg::OPC_JAL, 3'd0, 7'b1000000));
      send_word({12'd0, 13'($urandom()), rvid_pkg::OPC_SYSTEM});
      send_word({12'h001, 13'($urandom()), rvid_pkg::OPC_SYSTEM});
      send_word({25'($urandom()), 7'b1111111});
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);

      // random words, with a long run of back-to-back beats in the middle
      for (int i = 0; i < RandomWords; i++) begin
         maybe_idle(!(i >= 600 && i < 1100));
         send_word(random_word());
      end
      start <= 1'b0;

      while (sb.pending_decodes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("decoded %0d words, %0d results checked, %0d mismatches, %0d stray beats",
               words_sent, sb.checked, sb.mismatches, sb.orphans);
      $display("by format: R %0d I %0d S %0d B %0d U %0d J %0d unknown %0d",
               sb.per_format[rvid_pkg::FMT_R], sb.per_format[rvid_pkg::FMT_I],
               sb.per_format[rvid_pkg::FMT_S], sb.per_format[rvid_pkg::FMT_B],
               sb.per_format[rvid_pkg::FMT_U], sb.per_format[rvid_pkg::FMT_J],
               sb.per_format[rvid_pkg::FMT_UNKNOWN]);
      if (sb.mismatches == 0 && sb.orphans == 0 && sb.pending_decodes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rvid_pkg.sv
rtl/rv32i_instruction_decoder_unit.sv
rtl/rvid_checker.sv
tb/testbench.sv
